>>> rtl/core/cdn_pkg.sv
// Shared types and constants for the chain direction normaliser.
package cdn_pkg;

    localparam int AXES       = 3;
    localparam int POS_W      = 32;
    localparam int DIFF_W     = POS_W + 1;
    localparam int DIR_W      = 18;
    localparam int SEG_W      = 33;
    localparam int SQ_W       = 2 * POS_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int STEP_W     = SUM_W + 2;
    localparam int ROOT_W     = 34;
    localparam int MAG_W      = 17;
    localparam int ROOT_STEPS = 33;
    localparam int DIV_STEPS  = 33;
    localparam int DSQ_STEPS  = 17;
    localparam int CNT_W      = 6;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    // Register indexes (paddr[2])
    localparam logic REG_RESIZE_ENABLE = 1'b0;

    typedef logic [STEP_W-1:0] t_step;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_SUM,
        ST_ROOT,
        ST_DLOAD,
        ST_DIV,
        ST_DSQ,
        ST_DONE
    } t_state;

endpackage

>>> rtl/core/cdn_step_unit.sv
// Shared compare-and-subtract step used by the square roots and the division.
module cdn_step_unit (
    input  cdn_pkg::t_step i_a,
    input  cdn_pkg::t_step i_b,
    output logic           o_ge,
    output cdn_pkg::t_step o_diff
);
    import cdn_pkg::*;

    t_step w_diff;
    logic  w_borrow;

    assign {w_borrow, w_diff} = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~w_borrow;
    assign o_diff = w_diff;

endmodule

>>> rtl/core/cdn_cfg_regs.sv
// APB-style register port holding the resize enable bit.
module cdn_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cdn_pkg::ADDR_W-1:0]  paddr,
    input  logic [cdn_pkg::DATA_W-1:0]  pwdata,
    output logic [cdn_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic                        o_resize_enable
);
    import cdn_pkg::*;

    logic r_resize_enable;
    logic w_sel_resize;

    assign w_sel_resize = (paddr[2] == REG_RESIZE_ENABLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resize_enable <= 1'b0;
        end else if (psel && penable && pwrite && w_sel_resize) begin
            r_resize_enable <= pwdata[0];
        end
    end

    assign prdata          = w_sel_resize ? {{(DATA_W-1){1'b0}}, r_resize_enable} : '0;
    assign pready          = 1'b1;
    assign o_resize_enable = r_resize_enable;

endmodule

>>> rtl/core/chain_direction_normalizer_core.sv
// Top level: sequencer and datapath of the chain direction normaliser.
//
// Input channel: one word per particle (pos_x/y/z signed Q16.16, is_visual,
// first_of_pass), taken when i_valid is high and o_stall is low. The block
// keeps the previous position and, for a visual word, gives the unit
// direction toward it (signed Q1.16, truncated toward zero) and, with resize
// enabled, the segment length (unsigned Q17.16, rounded down).
// Output channel: one result word per input word, taken when o_valid is high
// and i_stall is low. The result sits in an output register, so a new input
// word is taken while an old result waits.
// Timing: one word at a time; o_stall is high from acceptance until the
// result is loaded. A visual word goes from acceptance to o_valid through
// squaring of each axis on one 32x32 multiplier, a sum, 33 square root steps,
// then per axis a load, 33 division steps and 17 square root steps, all on
// one shared compare-and-subtract unit, and the load of the output. A zero
// difference skips the per-axis work; a non-visual word goes straight to the
// output load. If the receiver stalls, the finished result waits in the
// sequencer until the output register frees.
// Reset clears the stored position, the resize bit and all valid flags.
module chain_direction_normalizer_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [cdn_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [cdn_pkg::POS_W-1:0]   i_pos_y,
    input  logic signed [cdn_pkg::POS_W-1:0]   i_pos_z,
    input  logic                               i_is_visual,
    input  logic                               i_first_of_pass,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [cdn_pkg::DIR_W-1:0]   o_dir_x,
    output logic signed [cdn_pkg::DIR_W-1:0]   o_dir_y,
    output logic signed [cdn_pkg::DIR_W-1:0]   o_dir_z,
    output logic                               o_dir_write,
    output logic [cdn_pkg::SEG_W-1:0]          o_seg_length,
    output logic                               o_length_write,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cdn_pkg::ADDR_W-1:0]         paddr,
    input  logic [cdn_pkg::DATA_W-1:0]         pwdata,
    output logic [cdn_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);
    import cdn_pkg::*;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_comp, n_comp;

    logic [POS_W-1:0]  r_prev [AXES];
    logic [POS_W-1:0]  r_mag  [AXES];
    logic              r_neg  [AXES];
    logic [SQ_W-1:0]   r_sq   [AXES];
    logic [DIR_W-1:0]  r_dir  [AXES];
    logic              r_vis;
    logic [SUM_W-1:0]  r_s;
    logic [SEG_W-1:0]  r_seg;
    t_step             r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [SUM_W-1:0]  r_src;

    logic              r_ovalid;
    logic [DIR_W-1:0]  r_odir [AXES];
    logic              r_odir_write;
    logic [SEG_W-1:0]  r_oseg;
    logic              r_olen_write;

    logic [POS_W-1:0]         w_cur [AXES];
    logic signed [DIFF_W-1:0] w_d   [AXES];
    logic [POS_W-1:0]         w_mag [AXES];
    logic                     w_accept;
    logic                     w_out_load;
    logic                     w_resize;

    t_step             w_a, w_b, w_diff, w_rem_nx;
    logic              w_ge;
    logic [ROOT_W-1:0] w_root_nx;
    logic [MAG_W-1:0]  w_dmag;

    cdn_cfg_regs u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_resize_enable (w_resize)
    );

    cdn_step_unit u_step (
        .i_a    (w_a),
        .i_b    (w_b),
        .o_ge   (w_ge),
        .o_diff (w_diff)
    );

    assign w_cur[0] = i_pos_x;
    assign w_cur[1] = i_pos_y;
    assign w_cur[2] = i_pos_z;

    // Difference previous minus current; zero on the first word of a pass
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            if (i_first_of_pass) begin
                w_d[a] = '0;
            end else begin
                w_d[a] = $signed({r_prev[a][POS_W-1], r_prev[a]})
                       - $signed({w_cur[a][POS_W-1], w_cur[a]});
            end
            w_mag[a] = w_d[a][DIFF_W-1] ? POS_W'(-w_d[a]) : w_d[a][POS_W-1:0];
        end
    end

    assign o_stall    = (r_state != ST_IDLE);
    assign w_accept   = i_valid && (r_state == ST_IDLE);
    assign w_out_load = (r_state == ST_DONE) && (!r_ovalid || !i_stall);

    // Operand select for the shared unit: division brings in one bit a step,
    // the square roots two
    always_comb begin
        if (r_state == ST_DIV) begin
            w_a = {r_rem[STEP_W-2:0], r_src[SUM_W-1]};
            w_b = {2'b00, r_s};
        end else begin
            w_a = {r_rem[STEP_W-3:0], r_src[SUM_W-1:SUM_W-2]};
            w_b = {{(STEP_W-ROOT_W-2){1'b0}}, r_root, 2'b01};
        end
    end

    assign w_rem_nx  = w_ge ? w_diff : w_a;
    assign w_root_nx = {r_root[ROOT_W-2:0], w_ge};

    assign w_dmag = w_root_nx[MAG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_comp  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_comp  <= n_comp;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_comp  = r_comp;
        case (r_state)
            ST_IDLE: begin
                n_comp = '0;
                if (i_valid) begin
                    n_state = i_is_visual ? ST_SQ : ST_DONE;
                end
            end
            ST_SQ: begin
                if (r_comp == 2'(AXES - 1)) begin
                    n_state = ST_SUM;
                    n_comp  = '0;
                end else begin
                    n_comp = r_comp + 2'd1;
                end
            end
            ST_SUM: begin
                n_state = ST_ROOT;
                n_cnt   = CNT_W'(ROOT_STEPS - 1);
            end
            ST_ROOT: begin
                if (r_cnt == '0) begin
                    n_state = (r_s == '0) ? ST_DONE : ST_DLOAD;
                    n_comp  = '0;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_DLOAD: begin
                n_state = ST_DIV;
                n_cnt   = CNT_W'(DIV_STEPS - 1);
            end
            ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ST_DSQ;
                    n_cnt   = CNT_W'(DSQ_STEPS - 1);
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_DSQ: begin
                if (r_cnt == '0) begin
                    if (r_comp == 2'(AXES - 1)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_DLOAD;
                        n_comp  = r_comp + 2'd1;
                    end
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Stored position: taken on every accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_prev[a] <= '0;
            end
        end else if (w_accept) begin
            for (int a = 0; a < AXES; a++) begin
                r_prev[a] <= w_cur[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_vis <= i_is_visual;
                    r_seg <= '0;
                    for (int a = 0; a < AXES; a++) begin
                        r_mag[a] <= w_mag[a];
                        r_neg[a] <= w_d[a][DIFF_W-1];
                        r_dir[a] <= '0;
                    end
                end
            end
            ST_SQ: begin
                r_sq[r_comp] <= r_mag[r_comp] * r_mag[r_comp];
            end
            ST_SUM: begin
                r_s    <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
                r_src  <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
                r_rem  <= '0;
                r_root <= '0;
            end
            ST_ROOT: begin
                r_rem  <= w_rem_nx;
                r_root <= w_root_nx;
                r_src  <= r_src << 2;
                if (r_cnt == '0) begin
                    r_seg <= w_root_nx[SEG_W-1:0];
                end
            end
            ST_DLOAD: begin
                // Numerator is the axis square shifted up by 32
                r_rem  <= STEP_W'(r_sq[r_comp][SQ_W-1:1]);
                r_src  <= {r_sq[r_comp][0], {(SUM_W-1){1'b0}}};
                r_root <= '0;
            end
            ST_DIV: begin
                if (r_cnt == '0) begin
                    // Hand the quotient to the square root
                    r_src  <= {1'b0, w_root_nx[DIV_STEPS-1:0], {(SUM_W-DIV_STEPS-1){1'b0}}};
                    r_rem  <= '0;
                    r_root <= '0;
                end else begin
                    r_rem  <= w_rem_nx;
                    r_root <= w_root_nx;
                    r_src  <= r_src << 1;
                end
            end
            ST_DSQ: begin
                r_rem  <= w_rem_nx;
                r_root <= w_root_nx;
                r_src  <= r_src << 2;
                if (r_cnt == '0) begin
                    r_dir[r_comp] <= r_neg[r_comp] ? DIR_W'(0) - {1'b0, w_dmag}
                                                   : {1'b0, w_dmag};
                end
            end
            ST_DONE: begin
                r_rem <= r_rem;
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    // Output register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            for (int a = 0; a < AXES; a++) begin
                r_odir[a] <= r_vis ? r_dir[a] : '0;
            end
            r_odir_write <= r_vis;
            r_oseg       <= (r_vis && w_resize) ? r_seg : '0;
            r_olen_write <= r_vis && w_resize;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_dir_x        = r_odir[0];
    assign o_dir_y        = r_odir[1];
    assign o_dir_z        = r_odir[2];
    assign o_dir_write    = r_odir_write;
    assign o_seg_length   = r_oseg;
    assign o_length_write = r_olen_write;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ST_IDLE))
        else $error("accepted word did not start the sequencer");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result loaded outside the done state");

    a_quotient_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIV) && (r_cnt == '0)) |-> (w_root_nx <= ROOT_W'(64'h1_0000_0000)))
        else $error("axis quotient above one");

    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DSQ) && (r_cnt == '0)) |=> (r_root <= ROOT_W'(65536)))
        else $error("direction magnitude above one");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |=> $stable(r_prev[0]) || ($past(r_state) == ST_IDLE))
        else $error("stored position changed while busy");

endmodule

>>> test/cdn_segment_checker.sv
// Checker for the chain direction normaliser: predicts every result word and compares it.
module cdn_segment_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic                               o_stall,
    input  logic signed [cdn_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [cdn_pkg::POS_W-1:0]   i_pos_y,
    input  logic signed [cdn_pkg::POS_W-1:0]   i_pos_z,
    input  logic                               i_is_visual,
    input  logic                               i_first_of_pass,
    input  logic                               o_valid,
    input  logic                               i_stall,
    input  logic signed [cdn_pkg::DIR_W-1:0]   o_dir_x,
    input  logic signed [cdn_pkg::DIR_W-1:0]   o_dir_y,
    input  logic signed [cdn_pkg::DIR_W-1:0]   o_dir_z,
    input  logic                               o_dir_write,
    input  logic [cdn_pkg::SEG_W-1:0]          o_seg_length,
    input  logic                               o_length_write,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cdn_pkg::ADDR_W-1:0]         paddr,
    input  logic [cdn_pkg::DATA_W-1:0]         pwdata,
    input  logic                               pready,
    output int                                 fail_count,
    output int                                 pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import cdn_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [AXES-1:0][DIR_W-1:0] dir;
        logic                       dir_write;
        logic [SEG_W-1:0]           seg_length;
        logic                       length_write;
    } t_segment;

    logic [AXES-1:0][POS_W-1:0] last_pos;
    logic                       resize_on;
    t_segment                   expected_segments [$];

    // Direction toward the previous particle and, with resize on, the segment length.
    function automatic t_segment predict_segment(input logic [AXES-1:0][POS_W-1:0] prev,
                                                 input logic [AXES-1:0][POS_W-1:0] cur,
                                                 input logic visual,
                                                 input logic resize);
        t_segment                    seg;
        logic [AXES-1:0][DIFF_W-1:0] diff;
        logic [AXES-1:0][POS_W-1:0]  mag;
        logic [127:0]                sum_sq;
        logic [127:0]                target;
        logic [127:0]                trial;
        logic [MAG_W-1:0]            unit;
        logic [ROOT_W-1:0]           root;
        seg = '0;
        if (visual) begin
            sum_sq = '0;
            for (int a = 0; a < AXES; a++) begin
                diff[a] = {prev[a][POS_W-1], prev[a]} - {cur[a][POS_W-1], cur[a]};
                mag[a]  = diff[a][DIFF_W-1] ? POS_W'(-diff[a]) : POS_W'(diff[a]);
                sum_sq  = sum_sq + 128'(mag[a]) * 128'(mag[a]);
            end
            seg.dir_write = 1'b1;
            if (sum_sq != 0) begin
                // largest q with q^2 * S <= m^2 * 2^32, i.e. truncated m * 2^16 / sqrt(S)
                for (int a = 0; a < AXES; a++) begin
                    target = (128'(mag[a]) * 128'(mag[a])) << 32;
                    unit   = '0;
                    for (int b = MAG_W - 1; b >= 0; b--) begin
                        trial = 128'(unit | (MAG_W'(1) << b));
                        if (trial * trial * sum_sq <= target)
                            unit = MAG_W'(trial);
                    end
                    seg.dir[a] = diff[a][DIFF_W-1] ? -DIR_W'(unit) : DIR_W'(unit);
                end
            end
            if (resize) begin
                root = '0;
                for (int b = SEG_W - 1; b >= 0; b--) begin
                    trial = 128'(root | (ROOT_W'(1) << b));
                    if (trial * trial <= sum_sq)
                        root = ROOT_W'(trial);
                end
                seg.seg_length   = SEG_W'(root);
                seg.length_write = 1'b1;
            end
        end
        return seg;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endtask

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    always @(posedge i_clk) begin
        logic [AXES-1:0][POS_W-1:0] cur;
        logic [AXES-1:0][POS_W-1:0] prev;
        t_segment                   got;
        t_segment                   want;
        if (!i_rst_n) begin
            last_pos  = '0;
            resize_on = 1'b0;
            expected_segments.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[ADDR_W-1] == REG_RESIZE_ENABLE)
                resize_on = pwdata[0];
            // compare first: a word accepted at this edge cannot have its result out yet
            if (o_valid && !i_stall) begin
                got.dir[0]       = o_dir_x;
                got.dir[1]       = o_dir_y;
                got.dir[2]       = o_dir_z;
                got.dir_write    = o_dir_write;
                got.seg_length   = o_seg_length;
                got.length_write = o_length_write;
                if (expected_segments.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result word with none expected, dir %0h %0h %0h",
                                 $time, o_dir_x, o_dir_y, o_dir_z);
                end else begin
                    want = expected_segments.pop_front();
                    for (int a = 0; a < AXES; a++) begin
                        if (got.dir[a] !== want.dir[a])
                            report_mismatch($sformatf("dir[%0d]", a), 64'(want.dir[a]),
                                            64'(got.dir[a]));
                    end
                    if (got.dir_write !== want.dir_write)
                        report_mismatch("dir_write", 64'(want.dir_write),
                                        64'(got.dir_write));
                    if (got.seg_length !== want.seg_length)
                        report_mismatch("seg_length", 64'(want.seg_length),
                                        64'(got.seg_length));
                    if (got.length_write !== want.length_write)
                        report_mismatch("length_write", 64'(want.length_write),
                                        64'(got.length_write));
                end
            end
            if (i_valid && !o_stall) begin
                cur  = {i_pos_z, i_pos_y, i_pos_x};
                prev = i_first_of_pass ? cur : last_pos;
                expected_segments.push_back(predict_segment(prev, cur, i_is_visual, resize_on));
                last_pos = cur;
            end
        end
        pending_count = expected_segments.size();
    end

endmodule

>>> test/chain_direction_normalizer_core_tb.sv
// Testbench top for the chain direction normaliser: stimulus, receiver stalls and verdict.
module chain_direction_normalizer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cdn_pkg::*;

    localparam logic             REG_SPARE     = 1'b1;
    localparam logic [POS_W-1:0] POS_MAX       = 32'h7FFF_FFFF;
    localparam logic [POS_W-1:0] POS_MIN       = 32'h8000_0000;
    localparam int               RANDOM_PHASES = 4;
    localparam int               PHASE_WORDS   = 100;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic signed [POS_W-1:0]  i_pos_x;
    logic signed [POS_W-1:0]  i_pos_y;
    logic signed [POS_W-1:0]  i_pos_z;
    logic                     i_is_visual;
    logic                     i_first_of_pass;
    logic                     o_valid;
    logic                     i_stall;
    logic signed [DIR_W-1:0]  o_dir_x;
    logic signed [DIR_W-1:0]  o_dir_y;
    logic signed [DIR_W-1:0]  o_dir_z;
    logic                     o_dir_write;
    logic [SEG_W-1:0]         o_seg_length;
    logic                     o_length_write;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ADDR_W-1:0]        paddr;
    logic [DATA_W-1:0]        pwdata;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;
    int                       fail_count;
    int                       pending_count;

    logic [AXES-1:0][POS_W-1:0] sent_pos;

    chain_direction_normalizer_core DUT (.*);

    cdn_segment_checker u_checker (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_particle(input logic [AXES-1:0][POS_W-1:0] pos, input logic visual,
                                 input logic first);
        int pick;
        int gap;
        @(negedge i_clk);
        i_valid         <= 1'b1;
        i_pos_x         <= pos[0];
        i_pos_y         <= pos[1];
        i_pos_z         <= pos[2];
        i_is_visual     <= visual;
        i_first_of_pass <= first;
        do @(posedge i_clk); while (o_stall);
        sent_pos = pos;
        pick = $urandom_range(0, 99);
        gap  = pick < 50 ? 0 : pick < 90 ? $urandom_range(1, 3) : $urandom_range(8, 40);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic write_register(input logic index, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
    endtask

    initial begin : receiver_stall
        int   pick;
        int   len;
        logic level;
        i_stall = 1'b0;
        forever begin
            pick = $urandom_range(0, 15);
            if (pick < 2) begin
                level = 1'b0;
                len   = $urandom_range(20, 120);
            end else if (pick == 2) begin
                level = 1'b1;
                len   = $urandom_range(10, 40);
            end else begin
                level = $urandom_range(0, 2) == 0;
                len   = $urandom_range(1, 3);
            end
            @(negedge i_clk);
            i_stall <= level;
            repeat (len - 1) @(negedge i_clk);
        end
    end

    initial begin : stimulus
        logic [AXES-1:0][POS_W-1:0] pos;
        logic [DATA_W-1:0]          junk;
        logic                       visual;
        logic                       first;
        int                         step;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_pos_x         = '0;
        i_pos_y         = '0;
        i_pos_z         = '0;
        i_is_visual     = 1'b0;
        i_first_of_pass = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        sent_pos        = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // resize off from reset
        send_particle({32'd0, 32'd0, 32'd0}, 1'b1, 1'b1);
        send_particle({POS_MAX, POS_MAX, POS_MAX}, 1'b1, 1'b0);
        send_particle({32'd7, 32'd6, 32'd5}, 1'b0, 1'b0);
        wait_for_results();
        write_register(REG_RESIZE_ENABLE, 32'hFFFF_FFFF);

        send_particle({POS_MAX, POS_MAX, POS_MAX}, 1'b0, 1'b1);
        // longest possible segment
        send_particle({POS_MIN, POS_MIN, POS_MIN}, 1'b1, 1'b0);
        send_particle({32'd0, POS_MIN, POS_MAX}, 1'b1, 1'b0);
        send_particle({32'd1, POS_MIN, POS_MAX}, 1'b1, 1'b0);
        // zero difference without a new pass
        send_particle({32'd1, POS_MIN, POS_MAX}, 1'b1, 1'b0);
        send_particle({32'd1, POS_MIN, 32'h7FFF_FFFE}, 1'b1, 1'b0);
        send_particle({32'd2, 32'h8000_0001, POS_MAX}, 1'b1, 1'b0);
        send_particle({32'd0, 32'd0, 32'd0}, 1'b1, 1'b1);
        send_particle({32'hFFFE_0000, 32'h0002_0000, 32'h0001_0000}, 1'b1, 1'b0);
        send_particle({32'hFFFE_0000, 32'h0002_0004, 32'h0001_0003}, 1'b1, 1'b0);
        send_particle({32'h0F0F_0F0F, 32'h9ABC_DEF0, 32'h1234_5678}, 1'b0, 1'b1);
        send_particle({32'hF0F0_F0F0, 32'h6543_210F, 32'hEDCB_A987}, 1'b1, 1'b0);
        send_particle({32'd0, 32'd0, 32'd0}, 1'b1, 1'b1);
        send_particle({POS_MIN, POS_MAX, POS_MIN}, 1'b1, 1'b0);
        wait_for_results();
        // spare address: resize must stay on
        write_register(REG_SPARE, 32'h0000_0000);
        send_particle({32'd1, 32'd1, 32'd1}, 1'b1, 1'b0);
        wait_for_results();
        write_register(REG_RESIZE_ENABLE, 32'hFFFF_FFFE);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            junk = $urandom;
            junk[0] = (phase % 2) == 0;
            write_register(REG_RESIZE_ENABLE, junk);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                pos    = sent_pos;
                visual = $urandom_range(0, 6) != 0;
                first  = $urandom_range(0, 11) == 0;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        // small steps along the chain
                        for (int a = 0; a < AXES; a++) begin
                            step   = $urandom;
                            pos[a] = pos[a] + (step >>> $urandom_range(1, 31));
                        end
                    end
                    4, 5: begin
                        for (int a = 0; a < AXES; a++)
                            pos[a] = $urandom;
                    end
                    6: begin
                        step = $urandom;
                        pos[$urandom_range(0, AXES - 1)] += step >>> $urandom_range(0, 31);
                    end
                    7: begin
                        // hold the position: zero difference
                    end
                    8: begin
                        for (int a = 0; a < AXES; a++) begin
                            case ($urandom_range(0, 2))
                                0:       pos[a] = POS_MAX;
                                1:       pos[a] = POS_MIN;
                                default: pos[a] = '0;
                            endcase
                        end
                    end
                    default: begin
                        for (int a = 0; a < AXES; a++)
                            pos[a] = $urandom;
                        first = 1'b1;
                    end
                endcase
                send_particle(pos, visual, first);
            end
            wait_for_results();
        end

        repeat (250) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
